// ===== rtl/core/rbf_pkg.sv =====
// Shared types and constants for the ring buffer FIFO core.
// No dependencies; compile first.
`default_nettype none

package rbf_pkg;

   localparam int DEPTH       = 256;
   localparam int ELEM_WIDTH  = 8;
   localparam int MAX_REQUEST = 64;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int POS_W       = ADDR_W + 1;
   localparam int CMD_W       = 3;
   localparam int REQ_W       = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 3'd0,
      CMD_POP   = 3'd1,
      CMD_PEEK  = 3'd2,
      CMD_RSPAN = 3'd3,
      CMD_WSPAN = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [ELEM_WIDTH-1:0] push_data;
      logic [REQ_W-1:0]      request_count;
   } req_type;

   typedef struct packed {
      logic [ELEM_WIDTH-1:0] out_data;
      logic                  valid_res;
      logic                  last;
      logic [REQ_W-1:0]      granted;
      logic [ADDR_W-1:0]     span_offset;
      logic [POS_W-1:0]      span_length;
      logic [POS_W-1:0]      fill_level;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic issue;
      logic load_elem;
      logic load_last;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic             is_stream;
      logic [REQ_W-1:0] grant_n;
      logic             out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/rbf_channels.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on rbf_pkg.
`default_nettype none

interface rbf_req_if;
   import rbf_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source  (output valid, output payload, input ready);
   modport sink    (input valid, input payload, output ready);
   modport monitor (input valid, input ready, input payload);
endinterface

interface rbf_rsp_if;
   import rbf_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source  (output valid, output payload, input ready);
   modport sink    (input valid, input payload, output ready);
   modport monitor (input valid, input ready, input payload);
endinterface

`default_nettype wire

// ===== rtl/core/rbf_dpath.sv =====
// Datapath: positions, element memory, read register, result register.
// Depends on rbf_pkg; driven by rbf_ctrl commands.
`default_nettype none

module rbf_dpath (
   input  logic            clock,
   input  logic            reset,
   input  rbf_pkg::req_type req_payload,
   input  rbf_pkg::ctl_type ctl,
   input  logic            rsp_ready,
   output rbf_pkg::sts_type sts,
   output logic            rsp_valid,
   output rbf_pkg::rsp_type rsp_payload
);
   import rbf_pkg::*;

   logic [ELEM_WIDTH-1:0] mem [DEPTH];

   logic [POS_W-1:0]      wr_pos_ff, wr_pos_in;
   logic [POS_W-1:0]      rd_pos_ff, rd_pos_in;
   logic [ADDR_W-1:0]     rd_addr_ff, rd_addr_in;
   logic [ELEM_WIDTH-1:0] rd_data_ff;
   logic [REQ_W-1:0]      grant_ff, grant_in;
   logic [POS_W-1:0]      fill_after_ff, fill_after_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;

   logic [POS_W-1:0]      fill;
   logic                  full;
   logic [ADDR_W-1:0]     in_off, out_off;
   logic [REQ_W-1:0]      req_n, grant_n;
   logic                  is_pick, mem_wr, direct;
   rsp_type               direct_rsp, elem_rsp;

   assign fill    = wr_pos_ff - rd_pos_ff;
   assign full    = fill[POS_W-1];   // fill never exceeds DEPTH
   assign in_off  = wr_pos_ff[ADDR_W-1:0];
   assign out_off = rd_pos_ff[ADDR_W-1:0];

   assign req_n   = (req_payload.request_count > REQ_W'(MAX_REQUEST)) ?
                    REQ_W'(MAX_REQUEST) : req_payload.request_count;
   assign grant_n = (POS_W'(req_n) > fill) ? fill[REQ_W-1:0] : req_n;
   assign is_pick = (req_payload.cmd == CMD_POP) || (req_payload.cmd == CMD_PEEK);

   assign sts.is_stream = is_pick && (grant_n != '0);
   assign sts.grant_n   = grant_n;
   assign sts.out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      direct_rsp            = '0;
      direct_rsp.last       = 1'b1;
      direct_rsp.fill_level = fill;
      mem_wr                = 1'b0;
      wr_pos_in             = wr_pos_ff;
      rd_pos_in             = rd_pos_ff;
      rd_addr_in            = rd_addr_ff;
      grant_in              = grant_ff;
      fill_after_in         = fill_after_ff;

      if (ctl.accept) begin
         case (req_payload.cmd) inside
            CMD_PUSH: begin
               if (!full) begin
                  mem_wr                = 1'b1;
                  wr_pos_in             = wr_pos_ff + POS_W'(1);
                  direct_rsp.valid_res  = 1'b1;
                  direct_rsp.granted    = REQ_W'(1);
                  direct_rsp.fill_level = fill + POS_W'(1);
               end
            end
            CMD_POP, CMD_PEEK: begin
               rd_addr_in = out_off;
               grant_in   = grant_n;
               if (req_payload.cmd == CMD_POP) begin
                  fill_after_in = fill - POS_W'(grant_n);
                  rd_pos_in     = rd_pos_ff + POS_W'(grant_n);
               end else begin
                  fill_after_in = fill;
               end
            end
            CMD_RSPAN: begin
               if (fill != '0) begin
                  direct_rsp.span_offset = out_off;
                  if (out_off < in_off)
                     direct_rsp.span_length = POS_W'(in_off) - POS_W'(out_off);
                  else
                     direct_rsp.span_length = POS_W'(DEPTH) - POS_W'(out_off);
               end
            end
            CMD_WSPAN: begin
               if (!full) begin
                  direct_rsp.span_offset = in_off;
                  if (out_off > in_off)
                     direct_rsp.span_length = POS_W'(out_off) - POS_W'(in_off);
                  else
                     direct_rsp.span_length = POS_W'(DEPTH) - POS_W'(in_off);
               end
            end
            default: ;
         endcase
      end

      if (ctl.issue)
         rd_addr_in = rd_addr_ff + ADDR_W'(1);
   end

   always_comb begin
      elem_rsp            = '0;
      elem_rsp.out_data   = rd_data_ff;
      elem_rsp.valid_res  = 1'b1;
      elem_rsp.last       = ctl.load_last;
      elem_rsp.granted    = grant_ff;
      elem_rsp.fill_level = fill_after_ff;
   end

   assign direct       = ctl.accept && !sts.is_stream;
   assign out_in       = direct ? direct_rsp : (ctl.load_elem ? elem_rsp : out_ff);
   assign out_valid_in = direct || ctl.load_elem || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         out_valid_ff <= out_valid_in;
      end
      rd_addr_ff    <= rd_addr_in;
      grant_ff      <= grant_in;
      fill_after_ff <= fill_after_in;
      out_ff        <= out_in;
   end

   // element store, registered read
   always_ff @(posedge clock) begin
      if (mem_wr)
         mem[in_off] <= req_payload.push_data;
      if (ctl.issue)
         rd_data_ff <= mem[rd_addr_ff];
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rbf_ctrl.sv =====
// Controller: request acceptance and element streaming sequencer.
// Depends on rbf_pkg; commands rbf_dpath.
`default_nettype none

module rbf_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  rbf_pkg::sts_type sts,
   output rbf_pkg::ctl_type ctl
);
   import rbf_pkg::*;

   typedef enum logic {ST_IDLE, ST_STREAM} state_type;

   state_type        state_ff, state_in;
   logic [REQ_W-1:0] remain_ff, remain_in;   // reads still to issue
   logic             pend_ff, pend_in;       // read register holds an element
   logic             pend_last_ff, pend_last_in;

   always_comb begin
      req_ready     = (state_ff == ST_IDLE) && sts.out_free;
      ctl.accept    = req_ready && req_valid;
      ctl.load_elem = pend_ff && sts.out_free;
      ctl.load_last = pend_last_ff;
      ctl.issue     = (state_ff == ST_STREAM) && (remain_ff != '0) &&
                      (!pend_ff || ctl.load_elem);

      state_in     = state_ff;
      remain_in    = remain_ff;
      pend_in      = ctl.issue || (pend_ff && !ctl.load_elem);
      pend_last_in = ctl.issue ? (remain_ff == REQ_W'(1)) : pend_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.accept && sts.is_stream) begin
               state_in  = ST_STREAM;
               remain_in = sts.grant_n;
            end
         end
         ST_STREAM: begin
            if (ctl.issue)
               remain_in = remain_ff - REQ_W'(1);
            if (ctl.load_elem && pend_last_ff)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         remain_ff    <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remain_ff    <= remain_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ring_buffer_fifo_core.sv =====
// Top level of the ring buffer FIFO core.
// Depends on rbf_pkg, rbf_channels, rbf_ctrl and rbf_dpath.
//
// Usage:
//  - req_if carries one request (cmd, push_data, request_count); it is
//    taken at a clock edge with valid and ready both high.
//  - rsp_if returns results through a registered output stage.
//  - Push, span queries, refused or empty pops/peeks: one result, visible
//    the cycle after the request is taken; back to back at one per cycle
//    while the receiver keeps up.
//  - Pop/peek of n elements: n results, one per cycle while the receiver
//    keeps up. The request first moves the controller into its streaming
//    state; each element is then read through the element memory's
//    registered read port into the output stage. No new request is taken
//    until the last element has entered the output stage.
//  - Receiver stall: the output stage holds its result; the read register
//    holds the next element, so nothing is lost and reads pause.
//  - Reset (synchronous): positions cleared, FIFO empty, output empty.
//    The element memory is not cleared; only written entries are read.
`default_nettype none

module ring_buffer_fifo_core (
   input  logic          clock,
   input  logic          reset,
   rbf_req_if.sink       req_if,
   rbf_rsp_if.source     rsp_if
);
   import rbf_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // sequencer: owns ready and the element stream pacing
   rbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // storage, pointer math and result register
   rbf_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_if.payload),
      .ctl         (ctl),
      .rsp_ready   (rsp_if.ready),
      .sts         (sts),
      .rsp_valid   (rsp_if.valid),
      .rsp_payload (rsp_if.payload)
   );

endmodule

`default_nettype wire

// ===== rtl/core/rbf_checker.sv =====
// Port-level checks for ring_buffer_fifo_core, attached by bind.
// Depends on rbf_pkg.
`default_nettype none

module rbf_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rbf_pkg::rsp_type rsp_payload
);
   import rbf_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_no_move_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.valid_res |->
         rsp_payload.last && (rsp_payload.granted == '0))
      else $error("non-moving result must be single and grant nothing");

   a_stream_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |->
         rsp_payload.valid_res && (rsp_payload.granted != '0) &&
         (rsp_payload.span_length == '0))
      else $error("mid-stream result malformed");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.fill_level <= POS_W'(DEPTH))
      else $error("fill level beyond capacity");

endmodule

bind ring_buffer_fifo_core rbf_checker u_rbf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

`default_nettype wire
